// ===== design/boolean_threshold_network_relaxer_top_macros.svh =====
// assertion macros for the relaxer top level
`ifndef BOOLEAN_THRESHOLD_NETWORK_RELAXER_TOP_MACROS_SVH
`define BOOLEAN_THRESHOLD_NETWORK_RELAXER_TOP_MACROS_SVH
// implication checked on every clock edge outside reset
`define BTNR_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: check failed");
// next-cycle implication checked outside reset
`define BTNR_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: check failed");
`endif

// ===== design/btnr_pkg.sv =====
// shared types and constants of the threshold network relaxer
package btnr_pkg;
  localparam int STEP_BITS   = 20;
  localparam int ENERGY_BITS = 17;
  localparam logic [STEP_BITS-1:0] STEP_LIMIT_RESET = 20'd100000;

  typedef enum logic [1:0] {
    ACT_WRITE  = 2'd0,
    ACT_LOAD   = 2'd1,
    ACT_STEP   = 2'd2,
    ACT_ENERGY = 2'd3
  } action_t;

  // controller to datapath
  typedef struct packed {
    logic latch_in;   // capture input item
    logic wr_weight;  // write weight memory
    logic load_state; // load node bits, clear counter
    logic clr_acc;    // clear row accumulators
    logic clr_mem;    // write zero to the next weight cell
    logic row_issue;  // issue row read
    logic row_valid;  // read data present for the row issued last cycle
    logic flip;       // apply the selected flip
    logic pick_start; // start unstable scan
    logic pick_step;  // examine one node in scan
    logic emit;       // drive result strobe
  } btnr_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic row_last;   // last cell of the last row issued
    logic pick_last;  // scan at last node
  } btnr_stat_t;
endpackage

// ===== design/btnr_ram.sv =====
// generic simple dual port ram, one write and one read port, with registered read
module btnr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

// ===== design/btnr_datapath.sv =====
// weight memory, row accumulators, unstable scan and result registers
module btnr_datapath import btnr_pkg::*; #(
  parameter int NODE_COUNT  = 16,
  parameter int WEIGHT_BITS = 8
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  btnr_cmd_t              cmd,
  output btnr_stat_t             stat,
  input  logic [1:0]             in_action,
  input  logic [3:0]             in_target_node,
  input  logic [3:0]             in_source_node,
  input  logic signed [7:0]      in_link_weight,
  input  logic [15:0]            in_start_state,
  input  logic [15:0]            in_random_fraction,
  input  logic                   cfg_we,
  input  logic [STEP_BITS-1:0]   cfg_wdata,
  output logic                   is_step,
  output logic [3:0]             out_flipped_node,
  output logic                   out_flipped,
  output logic [4:0]             out_unstable_count,
  output logic [STEP_BITS-1:0]   out_step_count,
  output logic                   out_done_res,
  output logic signed [ENERGY_BITS-1:0] out_energy
);
  localparam int NB = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;
  localparam int AB = 2 * NB;
  localparam int CB = $clog2(NODE_COUNT + 1);
  localparam int SB = WEIGHT_BITS + NB + 1;
  localparam int EB = WEIGHT_BITS + AB + 2;

  action_t                    act_r;
  logic [15:0]                frac_r;
  logic [NODE_COUNT-1:0]      bits_r;
  logic [STEP_BITS-1:0]       cnt_r, limit_r;
  logic [NB-1:0]              row_r, col_r, rrow_r, rcol_r;
  logic signed [SB-1:0]       sum_r [NODE_COUNT];
  logic signed [EB-1:0]       en_r;
  logic [NODE_COUNT-1:0]      unst;
  logic [CB-1:0]              ucnt;
  logic [CB-1:0]              k_r, seen_r;
  logic [NB-1:0]              scan_r, pick_r;
  logic                       found_r, fl_r;
  logic [WEIGHT_BITS-1:0]     rdata;
  logic signed [WEIGHT_BITS-1:0] w;
  logic [CB+15:0]             prod;
  logic                       tgt_ok, src_ok;
  logic                       ram_we;
  logic [AB-1:0]              ram_waddr;
  logic [WEIGHT_BITS-1:0]     ram_wdata;

  assign w = $signed(rdata);
  assign tgt_ok = ({28'd0, in_target_node} < 32'(NODE_COUNT));
  assign src_ok = ({28'd0, in_source_node} < 32'(NODE_COUNT));

  // clearing pass after reset writes zero cell by cell, else the item's weight
  assign ram_we    = cmd.clr_mem || (cmd.wr_weight && tgt_ok && src_ok);
  assign ram_waddr = cmd.clr_mem ? AB'({row_r, col_r}) :
                     AB'({in_target_node[NB-1:0], in_source_node[NB-1:0]});
  assign ram_wdata = cmd.clr_mem ? '0 : WEIGHT_BITS'(in_link_weight);

  btnr_ram #(.WIDTH(WEIGHT_BITS), .DEPTH(1 << AB)) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(AB'({row_r, col_r})),
    .rdata(rdata)
  );

  always_comb begin
    for (int i = 0; i < NODE_COUNT; i++)
      unst[i] = (sum_r[i] != '0) && ((sum_r[i] > 0) != bits_r[i]);
    ucnt = '0;
    for (int i = 0; i < NODE_COUNT; i++) ucnt = ucnt + CB'(unst[i]);
  end

  assign prod = {{CB{1'b0}}, frac_r} * {16'd0, ucnt};
  assign is_step = (act_r == ACT_STEP) && (ucnt != '0) && (cnt_r < limit_r);
  // cells issued row-major, one weight per cycle
  assign stat.row_last  = (row_r == NB'(NODE_COUNT-1)) && (col_r == NB'(NODE_COUNT-1));
  assign stat.pick_last = (scan_r == NB'(NODE_COUNT-1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bits_r <= '0;
      cnt_r <= '0;
      limit_r <= STEP_LIMIT_RESET;
      out_flipped <= 1'b0;
      row_r <= '0;
      col_r <= '0;
    end else begin
      if (cfg_we) limit_r <= cfg_wdata;
      if (cmd.latch_in) begin
        act_r <= action_t'(in_action);
        frac_r <= in_random_fraction;
        fl_r <= 1'b0;
        pick_r <= '0;
      end
      if (cmd.load_state) begin
        bits_r <= NODE_COUNT'(in_start_state);
        cnt_r <= '0;
      end
      if (cmd.clr_acc) begin
        row_r <= '0; col_r <= '0; en_r <= '0;
        for (int i = 0; i < NODE_COUNT; i++) sum_r[i] <= '0;
      end
      if (cmd.row_issue || cmd.clr_mem) begin
        if (col_r == NB'(NODE_COUNT-1)) begin
          col_r <= '0; row_r <= row_r + 1'b1;
        end else col_r <= col_r + 1'b1;
      end
      if (cmd.row_issue) begin
        rrow_r <= row_r; rcol_r <= col_r;
      end
      if (cmd.row_valid) begin
        if (bits_r[rcol_r]) sum_r[rrow_r] <= sum_r[rrow_r] + SB'(w);
        if (bits_r[rrow_r] == bits_r[rcol_r]) en_r <= en_r - EB'(w);
        else en_r <= en_r + EB'(w);
      end
      if (cmd.pick_start) begin
        k_r <= prod[CB+15:16];
        seen_r <= '0; scan_r <= '0; found_r <= 1'b0;
      end
      if (cmd.pick_step) begin
        if (unst[scan_r] && !found_r) begin
          if (seen_r == k_r) begin
            pick_r <= scan_r; found_r <= 1'b1;
          end
          seen_r <= seen_r + 1'b1;
        end
        scan_r <= scan_r + 1'b1;
      end
      if (cmd.flip) begin
        bits_r[pick_r] <= ~bits_r[pick_r];
        cnt_r <= cnt_r + 1'b1;
        fl_r <= 1'b1;
      end
      out_flipped <= cmd.emit & fl_r;
      if (cmd.emit) begin
        out_flipped_node <= 4'(pick_r);
        out_unstable_count <= 5'(ucnt);
        out_step_count <= cnt_r;
        out_done_res <= (ucnt == '0) || (cnt_r >= limit_r);
        out_energy <= (act_r == ACT_ENERGY) ? ENERGY_BITS'(en_r) : '0;
      end
    end
  end
endmodule

// ===== design/btnr_ctrl.sv =====
// sequencing state machine of the relaxer
module btnr_ctrl import btnr_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  input  logic [1:0] in_action,
  input  logic       is_step,
  input  btnr_stat_t stat,
  output btnr_cmd_t  cmd,
  output logic       busy,
  output logic       out_strobe
);
  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_SWEEP, S_DRAIN, S_EVAL, S_PICK, S_FLIP, S_EMIT
  } state_t;

  state_t state_r;
  logic   second_r;  // second sweep after a flip
  logic   v_r;       // read issued last cycle

  always_comb begin
    cmd = '0;
    cmd.latch_in   = (state_r == S_IDLE) && start;
    // weight lands at acceptance, before the first sweep read
    cmd.wr_weight  = (state_r == S_IDLE) && start && (in_action == ACT_WRITE);
    cmd.clr_mem    = (state_r == S_CLEAR);
    cmd.row_issue  = (state_r == S_SWEEP);
    cmd.row_valid  = v_r;
    cmd.pick_step  = (state_r == S_PICK);
    cmd.flip       = (state_r == S_FLIP);
    cmd.emit       = (state_r == S_EMIT);
    cmd.load_state = (state_r == S_IDLE) && start && (in_action == ACT_LOAD);
    cmd.clr_acc    = ((state_r == S_IDLE) && start) || (state_r == S_FLIP);
    // sums are final in S_EVAL, the state after the drain
    cmd.pick_start = (state_r == S_EVAL) && !second_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      busy <= 1'b1;
      out_strobe <= 1'b0;
      second_r <= 1'b0;
      v_r <= 1'b0;
    end else begin
      out_strobe <= (state_r == S_EMIT);
      v_r <= cmd.row_issue;
      case (state_r)
        S_CLEAR: if (stat.row_last) begin
          state_r <= S_IDLE; busy <= 1'b0;
        end
        S_IDLE: if (start) begin
          state_r <= S_SWEEP; busy <= 1'b1; second_r <= 1'b0;
        end
        S_SWEEP: if (stat.row_last) state_r <= S_DRAIN;
        S_DRAIN: state_r <= S_EVAL;
        S_EVAL:  state_r <= (!second_r && is_step) ? S_PICK : S_EMIT;
        S_PICK:  if (stat.pick_last) state_r <= S_FLIP;
        S_FLIP: begin
          state_r <= S_SWEEP; second_r <= 1'b1;
        end
        S_EMIT: begin
          state_r <= S_IDLE; busy <= 1'b0;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule

// ===== design/boolean_threshold_network_relaxer_top.sv =====
// top level of the boolean threshold network relaxer
// write, load, energy and held step items: one sweep over all weights, then the result
// relaxation step with a flip: sweep, unstable scan, flip, second sweep, then the result
// each sweep reads one weight per cycle
// reset: busy high during a pass that zeroes the weights; bits, count zero
// one item at a time; busy is low in the strobe cycle and the receiver cannot stall
`include "boolean_threshold_network_relaxer_top_macros.svh"
module boolean_threshold_network_relaxer_top import btnr_pkg::*; #(
  parameter int NODE_COUNT  = 16,
  parameter int WEIGHT_BITS = 8
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  output logic                   busy,
  input  logic [1:0]             in_action,
  input  logic [3:0]             in_target_node,
  input  logic [3:0]             in_source_node,
  input  logic signed [7:0]      in_link_weight,
  input  logic [15:0]            in_start_state,
  input  logic [15:0]            in_random_fraction,
  input  logic                   cfg_we,
  input  logic [STEP_BITS-1:0]   cfg_wdata,
  output logic                   out_strobe,
  output logic [3:0]             out_flipped_node,
  output logic                   out_flipped,
  output logic [4:0]             out_unstable_count,
  output logic [STEP_BITS-1:0]   out_step_count,
  output logic                   out_done_res,
  output logic signed [ENERGY_BITS-1:0] out_energy
);
  btnr_cmd_t  cmd;
  btnr_stat_t stat;
  logic       is_step;

  // controller: sequences clearing, sweeps, the pick scan and the flip
  btnr_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .start(start), .in_action(in_action),
    .is_step(is_step), .stat(stat), .cmd(cmd), .busy(busy), .out_strobe(out_strobe)
  );

  // datapath: weight memory, per-row sums, energy and result registers
  btnr_datapath #(.NODE_COUNT(NODE_COUNT), .WEIGHT_BITS(WEIGHT_BITS)) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .stat(stat),
    .in_action(in_action), .in_target_node(in_target_node),
    .in_source_node(in_source_node), .in_link_weight(in_link_weight),
    .in_start_state(in_start_state), .in_random_fraction(in_random_fraction),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata), .is_step(is_step),
    .out_flipped_node(out_flipped_node), .out_flipped(out_flipped),
    .out_unstable_count(out_unstable_count), .out_step_count(out_step_count),
    .out_done_res(out_done_res), .out_energy(out_energy)
  );

  // busy is already low while the result strobe is up
  `BTNR_ASSERT_IMP(a_strobe_frees, out_strobe, !busy)
  // flips happen only while an item is in flight
  `BTNR_ASSERT_IMP(a_flip_in_step, cmd.flip, busy)
  // an accepted item raises busy on the next cycle
  `BTNR_ASSERT_NXT(a_accept_busy, start && !busy, busy)
endmodule

// ===== sim/testbench.sv =====
// self-checking testbench for the boolean threshold network relaxer
module testbench import btnr_pkg::*; ;

  localparam int NODES = 16;
  localparam longint CYCLE_LIMIT = 5_000_000;

  // network predictor and queue of expected outcomes
  typedef struct {
    logic [3:0]  flipped_node;
    logic        flipped;
    logic [4:0]  unstable_count;
    logic [19:0] step_count;
    logic        done_res;
    logic [16:0] energy;
  } outcome_t;

  class relax_scoreboard;
    logic signed [7:0] weights [NODES][NODES];
    logic [15:0] bits_q;
    logic [19:0] flips;
    logic [19:0] limit;
    outcome_t pending[$];
    int errors;
    int checked;

    function void clear();
      for (int i = 0; i < NODES; i++)
        for (int j = 0; j < NODES; j++) weights[i][j] = '0;
      bits_q = '0;
      flips = '0;
      limit = STEP_LIMIT_RESET;
      errors = 0;
      checked = 0;
    endfunction

    function bit unstable(int i);
      int sum;
      sum = 0;
      for (int j = 0; j < NODES; j++)
        if (bits_q[j]) sum += weights[i][j];
      if (sum == 0) return 0;
      return (sum > 0) != bits_q[i];
    endfunction

    function int unstable_total();
      int n;
      n = 0;
      for (int i = 0; i < NODES; i++) n += unstable(i);
      return n;
    endfunction

    // predict the outcome of one accepted item
    function void note_item(action_t act, logic [3:0] tgt, logic [3:0] src,
                            logic signed [7:0] w, logic [15:0] st,
                            logic [15:0] frac);
      outcome_t o;
      int cnt, k, seen, sum;
      o = '{default: '0};
      case (act)
        ACT_WRITE: weights[tgt][src] = w;
        ACT_LOAD: begin
          bits_q = st;
          flips = '0;
        end
        ACT_STEP: begin
          cnt = unstable_total();
          if (cnt > 0 && flips < limit) begin
            k = int'((longint'(frac) * cnt) >> 16);
            seen = 0;
            for (int i = 0; i < NODES; i++) begin
              if (unstable(i)) begin
                if (seen == k) begin
                  o.flipped_node = 4'(i);
                  break;
                end
                seen++;
              end
            end
            bits_q[o.flipped_node] = ~bits_q[o.flipped_node];
            flips++;
            o.flipped = 1'b1;
          end
        end
        default: begin
          sum = 0;
          for (int i = 0; i < NODES; i++)
            for (int j = 0; j < NODES; j++)
              sum += (bits_q[i] == bits_q[j]) ? weights[i][j] : -weights[i][j];
          o.energy = 17'(-sum);
        end
      endcase
      cnt = unstable_total();
      o.unstable_count = 5'(cnt);
      o.step_count = flips;
      o.done_res = (cnt == 0 || flips >= limit);
      pending = {pending, o};
    endfunction

    function void check_result(outcome_t got);
      outcome_t e;
      if (pending.size() == 0) begin
        $error("result with nothing expected");
        errors++;
        return;
      end
      e = pending.pop_front();
      checked++;
      if (got.flipped_node !== e.flipped_node) begin
        $error("flipped_node expected %0d got %0d", e.flipped_node, got.flipped_node);
        errors++;
      end
      if (got.flipped !== e.flipped) begin
        $error("flipped expected %0d got %0d", e.flipped, got.flipped);
        errors++;
      end
      if (got.unstable_count !== e.unstable_count) begin
        $error("unstable_count expected %0d got %0d", e.unstable_count,
               got.unstable_count);
        errors++;
      end
      if (got.step_count !== e.step_count) begin
        $error("step_count expected %0d got %0d", e.step_count, got.step_count);
        errors++;
      end
      if (got.done_res !== e.done_res) begin
        $error("done_res expected %0d got %0d", e.done_res, got.done_res);
        errors++;
      end
      if (got.energy !== e.energy) begin
        $error("energy expected %0h got %0h", e.energy, got.energy);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [1:0] in_action = '0;
  logic [3:0] in_target_node = '0;
  logic [3:0] in_source_node = '0;
  logic signed [7:0] in_link_weight = '0;
  logic [15:0] in_start_state = '0;
  logic [15:0] in_random_fraction = '0;
  logic cfg_we = 1'b0;
  logic [STEP_BITS-1:0] cfg_wdata = '0;
  logic out_strobe;
  logic [3:0] out_flipped_node;
  logic out_flipped;
  logic [4:0] out_unstable_count;
  logic [STEP_BITS-1:0] out_step_count;
  logic out_done_res;
  logic signed [ENERGY_BITS-1:0] out_energy;

  relax_scoreboard sb;
  longint cycles = 0;
  int gap_pct = 0;
  int items_sent = 0;
  int counts_by_action [4];

  always #5 clk = ~clk;

  boolean_threshold_network_relaxer_top uut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_action(in_action), .in_target_node(in_target_node),
    .in_source_node(in_source_node), .in_link_weight(in_link_weight),
    .in_start_state(in_start_state), .in_random_fraction(in_random_fraction),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .out_strobe(out_strobe), .out_flipped_node(out_flipped_node),
    .out_flipped(out_flipped), .out_unstable_count(out_unstable_count),
    .out_step_count(out_step_count), .out_done_res(out_done_res),
    .out_energy(out_energy)
  );

  // results are sampled on the rising edge that ends their strobe cycle
  always @(posedge clk) begin
    outcome_t got;
    cycles <= cycles + 1;
    if (rst_n && out_strobe) begin
      got.flipped_node = out_flipped_node;
      got.flipped = out_flipped;
      got.unstable_count = out_unstable_count;
      got.step_count = out_step_count;
      got.done_res = out_done_res;
      got.energy = out_energy;
      sb.check_result(got);
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("FAIL");
      $finish;
    end
  end

  // drive one item; held until the block accepts it, start drops in a sender gap or on drain
  task automatic send_item(action_t act, logic [3:0] tgt, logic [3:0] src,
                           logic signed [7:0] w, logic [15:0] st,
                           logic [15:0] frac);
    bit taken;
    // random sender gap, on the falling edge like every other change
    while ($urandom_range(99) < gap_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start <= 1'b1;
    in_action <= act;
    in_target_node <= tgt;
    in_source_node <= src;
    in_link_weight <= w;
    in_start_state <= st;
    in_random_fraction <= frac;
    taken = 0;
    while (!taken) begin
      @(posedge clk);
      taken = !busy;
      if (taken) sb.note_item(act, tgt, src, w, st, frac);
      @(negedge clk);
    end
    items_sent++;
    counts_by_action[act]++;
  endtask

  // one item of the given action with random fields
  task automatic send_random(action_t act);
    logic [31:0] r0, r1, r2;
    r0 = $urandom;
    r1 = $urandom;
    r2 = $urandom;
    send_item(act, r0[3:0], r0[7:4], r0[15:8], r1[15:0], r2[15:0]);
  endtask

  // drain all results, then let the block settle before a register write
  task automatic drain();
    start <= 1'b0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (600) @(negedge clk);
  endtask

  task automatic write_limit(logic [19:0] value);
    drain();
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    sb.limit = value;
  endtask

  task automatic random_item();
    int pick;
    pick = $urandom_range(99);
    if (pick < 30)
      send_random(ACT_WRITE);
    else if (pick < 40)
      send_random(ACT_LOAD);
    else if (pick < 90)
      send_random(ACT_STEP);
    else
      send_random(ACT_ENERGY);
  endtask

  // a random network, a fresh start state, then a relaxation run and an energy query
  task automatic relax_episode(int steps);
    int links;
    links = $urandom_range(4, 20);
    for (int i = 0; i < links; i++)
      send_random(ACT_WRITE);
    send_random(ACT_LOAD);
    for (int i = 0; i < steps; i++)
      send_random(ACT_STEP);
    send_random(ACT_ENERGY);
  endtask

  initial begin
    sb = new();
    sb.clear();
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: empty network is done at once, energy of an all-zero store
    send_item(ACT_STEP, 4'd0, 4'd0, 8'sd0, 16'h0000, 16'hffff);
    send_item(ACT_ENERGY, 4'd0, 4'd0, 8'sd0, 16'h0000, 16'h0000);
    // extreme weights at two corners of the matrix, small weights elsewhere
    send_item(ACT_WRITE, 4'd0, 4'd15, -8'sd128, 16'hffff, 16'h0000);
    send_item(ACT_WRITE, 4'd15, 4'd0, 8'sd127, 16'h0000, 16'hffff);
    send_item(ACT_WRITE, 4'd3, 4'd3, -8'sd1, 16'h0000, 16'h0000);
    send_item(ACT_WRITE, 4'd7, 4'd15, 8'sd1, 16'h0000, 16'h0000);
    send_item(ACT_LOAD, 4'd15, 4'd15, 8'sd0, 16'hffff, 16'h0000);
    send_item(ACT_ENERGY, 4'd0, 4'd0, 8'sd0, 16'h0000, 16'h0000);
    // lowest and highest fraction pick the first and last unstable node
    send_item(ACT_STEP, 4'd0, 4'd0, 8'sd0, 16'h0000, 16'h0000);
    send_item(ACT_STEP, 4'd0, 4'd0, 8'sd0, 16'h0000, 16'hffff);
    send_item(ACT_LOAD, 4'd0, 4'd0, 8'sd0, 16'h8001, 16'hffff);
    send_item(ACT_STEP, 4'd0, 4'd0, 8'sd0, 16'h0000, 16'h8000);
    send_item(ACT_STEP, 4'd0, 4'd0, 8'sd0, 16'h0000, 16'hffff);
    // zero sum keeps the bit; remove a link again
    send_item(ACT_WRITE, 4'd0, 4'd15, 8'sd0, 16'h0000, 16'h0000);
    send_item(ACT_STEP, 4'd0, 4'd0, 8'sd0, 16'h0000, 16'h1234);
    send_item(ACT_ENERGY, 4'd0, 4'd0, 8'sd0, 16'h0000, 16'h0000);
    // write to the first cell, read back by the very next sweep
    send_item(ACT_WRITE, 4'd0, 4'd0, 8'sd5, 16'h0000, 16'h0000);
    send_item(ACT_ENERGY, 4'd0, 4'd0, 8'sd0, 16'h0000, 16'h0000);

    // step limit of one: the second step must hold
    write_limit(20'd1);
    send_item(ACT_LOAD, 4'd0, 4'd0, 8'sd0, 16'hffff, 16'h0000);
    send_item(ACT_STEP, 4'd0, 4'd0, 8'sd0, 16'h0000, 16'h0000);
    send_item(ACT_STEP, 4'd0, 4'd0, 8'sd0, 16'h0000, 16'h0000);
    // zero limit counts as done at once
    write_limit(20'd0);
    send_item(ACT_LOAD, 4'd0, 4'd0, 8'sd0, 16'h0001, 16'h0000);
    send_item(ACT_STEP, 4'd0, 4'd0, 8'sd0, 16'h0000, 16'h0000);

    // random phases: sender gaps, then none, across several limits
    write_limit(20'hfffff);
    gap_pct = 16;
    for (int e = 0; e < 10; e++) relax_episode($urandom_range(5, 40));
    for (int i = 0; i < 100; i++) random_item();

    write_limit(20'd3);
    gap_pct = 62;
    for (int e = 0; e < 10; e++) relax_episode($urandom_range(2, 10));

    write_limit(20'($urandom_range(4, 30)));
    gap_pct = 0;
    for (int e = 0; e < 12; e++) relax_episode($urandom_range(5, 40));
    for (int i = 0; i < 100; i++) random_item();

    write_limit(STEP_LIMIT_RESET);
    for (int e = 0; e < 6; e++) relax_episode($urandom_range(10, 40));

    drain();
    $display("sent %0d items: %0d weight writes, %0d loads, %0d steps, %0d energy queries",
             items_sent, counts_by_action[0], counts_by_action[1],
             counts_by_action[2], counts_by_action[3]);
    $display("%0d results checked across step limits 0, 1, 3, random, reset and max",
             sb.checked);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule
